// File: design/egbr_pkg.sv
package egbr_pkg;

    // Buffer geometry
    localparam int BUFFER_BYTES = 1024;
    localparam int C_ADDR_W     = $clog2(BUFFER_BYTES);
    localparam int C_LEN_W      = $clog2(BUFFER_BYTES + 1);

    // Field widths
    localparam int C_KIND_W  = 3;
    localparam int C_BYTE_W  = 8;
    localparam int C_NBITS_W = 6;
    localparam int C_SKIP_W  = 11;
    localparam int C_VALUE_W = 32;
    localparam int C_CFG_W   = 4;
    localparam int C_BR_W    = 4;
    localparam int C_CNT_W   = 6;
    localparam int C_ZERO_W  = 5;
    localparam int C_BIDX_W  = 3;
    localparam int C_CMP_W   = (C_LEN_W > C_SKIP_W) ? C_LEN_W : C_SKIP_W;

    // Limits
    localparam logic [C_NBITS_W-1:0] C_MAX_BITS      = 6'd32;
    localparam logic [C_ZERO_W-1:0]  C_MAX_ZEROS     = 5'd31;
    localparam logic [C_BR_W-1:0]    C_BITS_PER_BYTE = 4'd8;
    localparam logic [C_BR_W-1:0]    C_MIN_START     = 4'd1;

    // Command codes
    localparam logic [C_KIND_W-1:0] KIND_APPEND = 3'd0;
    localparam logic [C_KIND_W-1:0] KIND_READ   = 3'd1;
    localparam logic [C_KIND_W-1:0] KIND_PEEK   = 3'd2;
    localparam logic [C_KIND_W-1:0] KIND_UE     = 3'd3;
    localparam logic [C_KIND_W-1:0] KIND_SE     = 3'd4;
    localparam logic [C_KIND_W-1:0] KIND_SKIP   = 3'd5;
    localparam logic [C_KIND_W-1:0] KIND_CLEAR  = 3'd6;

    // Register port
    localparam int   C_PADDR_W      = 3;
    localparam int   C_PDATA_W      = 32;
    localparam logic REG_START_BITS = 1'b0;   // word index bit paddr[2]

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_LATCH,
        ST_ZEROS,
        ST_BITS,
        ST_FINISH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [C_VALUE_W-1:0] value;
        logic                 at_end;
        logic [C_SKIP_W-1:0]  bytes_skipped;
        logic                 append_dropped;
    } t_result;

endpackage

// File: design/egbr_cmd_if.sv
interface egbr_cmd_if import egbr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [C_KIND_W-1:0]  kind;
    logic [C_BYTE_W-1:0]  data_byte;
    logic [C_NBITS_W-1:0] bit_count;
    logic [C_SKIP_W-1:0]  skip_count;

    modport source (output valid, kind, data_byte, bit_count, skip_count, input ready);
    modport sink   (input valid, kind, data_byte, bit_count, skip_count, output ready);
endinterface

// File: design/egbr_rsp_if.sv
interface egbr_rsp_if import egbr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [C_VALUE_W-1:0] value;
    logic                 at_end;
    logic [C_SKIP_W-1:0]  bytes_skipped;
    logic                 append_dropped;

    modport source (output valid, value, at_end, bytes_skipped, append_dropped, input ready);
    modport sink   (input valid, value, at_end, bytes_skipped, append_dropped, output ready);
endinterface

// File: design/egbr_ram.sv
module egbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/egbr_core.sv
module egbr_core import egbr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    egbr_cmd_if.sink          i_cmd,
    input  logic [C_BR_W-1:0] i_start_bits,
    output logic              o_res_valid,
    output t_result           o_res,
    input  logic              i_res_ready
);

    // Control state
    t_state             r_state, n_state;
    t_state             r_ret, n_ret;
    logic [C_LEN_W-1:0] r_fill, n_fill;
    logic [C_LEN_W-1:0] r_cursor, n_cursor;
    logic [C_BR_W-1:0]  r_br, n_br;
    logic               r_ok, n_ok;

    // Datapath state
    logic [C_KIND_W-1:0]  r_kind, n_kind;
    logic [C_BYTE_W-1:0]  r_byte, n_byte;
    logic [C_VALUE_W-1:0] r_acc, n_acc;
    logic [C_CNT_W-1:0]   r_cnt, n_cnt;
    logic [C_ZERO_W-1:0]  r_zeros, n_zeros;
    logic [C_LEN_W-1:0]   r_save_cursor, n_save_cursor;
    logic [C_BR_W-1:0]    r_save_br, n_save_br;
    logic [C_VALUE_W-1:0] r_value, n_value;
    logic [C_SKIP_W-1:0]  r_skipped, n_skipped;
    logic                 r_dropped, n_dropped;

    // Byte store
    logic                w_ram_we;
    logic                w_ram_re;
    logic [C_BYTE_W-1:0] w_ram_rdata;

    egbr_ram #(
        .WIDTH (C_BYTE_W),
        .DEPTH (BUFFER_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_fill[C_ADDR_W-1:0]),
        .i_wdata (i_cmd.data_byte),
        .i_re    (w_ram_re),
        .i_raddr (r_cursor[C_ADDR_W-1:0]),
        .o_rdata (w_ram_rdata)
    );

    // Single-bit take from the cached cursor byte
    logic               w_end;
    logic               w_need_load;
    logic [C_BR_W-1:0]  w_br_dec;
    logic               w_cross;
    logic               w_bit;
    logic               w_end_after;
    logic [C_LEN_W-1:0] w_cursor_inc;

    assign w_end        = (r_cursor >= r_fill);
    assign w_need_load  = !w_end && !r_ok;
    assign w_br_dec     = r_br - 1'b1;
    assign w_cross      = (w_br_dec == '0);
    assign w_bit        = w_end ? 1'b0 : r_byte[w_br_dec[C_BIDX_W-1:0]];
    assign w_cursor_inc = r_cursor + 1'b1;
    assign w_end_after  = w_end || (w_cross && (w_cursor_inc == r_fill));

    // Skip clipping and buffer-full check
    logic               w_full;
    logic [C_LEN_W-1:0] w_left;
    logic [C_CMP_W-1:0] w_skip_req;
    logic [C_CMP_W-1:0] w_skip_left;
    logic [C_CMP_W-1:0] w_skip_take;

    assign w_full      = (r_fill == C_LEN_W'(BUFFER_BYTES));
    assign w_left      = w_end ? '0 : (r_fill - r_cursor);
    assign w_skip_req  = C_CMP_W'(i_cmd.skip_count);
    assign w_skip_left = C_CMP_W'(w_left);
    assign w_skip_take = (w_skip_req < w_skip_left) ? w_skip_req : w_skip_left;

    // Next state and datapath
    always_comb begin
        n_state       = r_state;
        n_ret         = r_ret;
        n_fill        = r_fill;
        n_cursor      = r_cursor;
        n_br          = r_br;
        n_ok          = r_ok;
        n_kind        = r_kind;
        n_byte        = r_byte;
        n_acc         = r_acc;
        n_cnt         = r_cnt;
        n_zeros       = r_zeros;
        n_save_cursor = r_save_cursor;
        n_save_br     = r_save_br;
        n_value       = r_value;
        n_skipped     = r_skipped;
        n_dropped     = r_dropped;
        w_ram_we      = 1'b0;
        w_ram_re      = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_cmd.valid) begin
                    n_kind    = i_cmd.kind;
                    n_value   = '0;
                    n_skipped = '0;
                    n_dropped = 1'b0;
                    n_state   = ST_DONE;
                    case (i_cmd.kind)
                        KIND_APPEND: begin
                            if (w_full) begin
                                n_dropped = 1'b1;
                            end else begin
                                w_ram_we = 1'b1;
                                n_fill   = r_fill + 1'b1;
                                n_ok     = 1'b0;
                            end
                        end
                        KIND_READ, KIND_PEEK: begin
                            n_cnt = (i_cmd.bit_count > C_MAX_BITS) ? C_MAX_BITS
                                                                    : i_cmd.bit_count;
                            n_acc         = '0;
                            n_save_cursor = r_cursor;
                            n_save_br     = r_br;
                            n_state       = ST_BITS;
                        end
                        KIND_UE, KIND_SE: begin
                            n_zeros = '0;
                            n_state = ST_ZEROS;
                        end
                        KIND_SKIP: begin
                            n_skipped = w_skip_take[C_SKIP_W-1:0];
                            n_cursor  = r_cursor + w_skip_take[C_LEN_W-1:0];
                            n_ok      = 1'b0;
                        end
                        KIND_CLEAR: begin
                            n_fill   = '0;
                            n_cursor = '0;
                            n_br     = i_start_bits;
                            n_ok     = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Fetch the cursor byte: address cycle, then capture
            ST_LOAD: begin
                w_ram_re = 1'b1;
                n_state  = ST_LATCH;
            end

            ST_LATCH: begin
                n_byte  = w_ram_rdata;
                n_ok    = 1'b1;
                n_state = r_ret;
            end

            // Exp-Golomb prefix, one bit per cycle while the cursor byte is cached
            ST_ZEROS: begin
                if (w_need_load) begin
                    n_ret   = ST_ZEROS;
                    n_state = ST_LOAD;
                end else begin
                    if (!w_end) begin
                        n_br     = w_cross ? C_BITS_PER_BYTE : w_br_dec;
                        n_cursor = w_cross ? w_cursor_inc : r_cursor;
                        if (w_cross) begin
                            n_ok = 1'b0;
                        end
                    end
                    if (w_bit || (r_zeros == C_MAX_ZEROS) || w_end_after) begin
                        n_acc   = C_VALUE_W'(1);
                        n_cnt   = C_CNT_W'(r_zeros);
                        n_state = ST_BITS;
                    end else begin
                        n_zeros = r_zeros + 1'b1;
                    end
                end
            end

            // Field or suffix bits, shifted in MSB first
            ST_BITS: begin
                if (r_cnt == '0) begin
                    n_state = ST_FINISH;
                end else if (w_need_load) begin
                    n_ret   = ST_BITS;
                    n_state = ST_LOAD;
                end else begin
                    if (!w_end) begin
                        n_br     = w_cross ? C_BITS_PER_BYTE : w_br_dec;
                        n_cursor = w_cross ? w_cursor_inc : r_cursor;
                        if (w_cross) begin
                            n_ok = 1'b0;
                        end
                    end
                    n_acc = {r_acc[C_VALUE_W-2:0], w_bit};
                    n_cnt = r_cnt - 1'b1;
                end
            end

            // Accumulator holds code+1 for ue/se (implicit leading one)
            ST_FINISH: begin
                case (r_kind)
                    KIND_UE: begin
                        n_value = r_acc - 1'b1;
                    end
                    KIND_SE: begin
                        n_value = r_acc[0] ? ('0 - {1'b0, r_acc[C_VALUE_W-1:1]})
                                           : {1'b0, r_acc[C_VALUE_W-1:1]};
                    end
                    KIND_PEEK: begin
                        n_value  = r_acc;
                        n_cursor = r_save_cursor;
                        n_br     = r_save_br;
                        n_ok     = 1'b0;
                    end
                    default: begin
                        n_value = r_acc;
                    end
                endcase
                n_state = ST_DONE;
            end

            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ret    <= ST_IDLE;
            r_fill   <= '0;
            r_cursor <= '0;
            r_br     <= C_BITS_PER_BYTE;
            r_ok     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_fill   <= n_fill;
            r_cursor <= n_cursor;
            r_br     <= n_br;
            r_ok     <= n_ok;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_kind        <= n_kind;
        r_byte        <= n_byte;
        r_acc         <= n_acc;
        r_cnt         <= n_cnt;
        r_zeros       <= n_zeros;
        r_save_cursor <= n_save_cursor;
        r_save_br     <= n_save_br;
        r_value       <= n_value;
        r_skipped     <= n_skipped;
        r_dropped     <= n_dropped;
    end

    assign i_cmd.ready          = (r_state == ST_IDLE);
    assign o_res_valid          = (r_state == ST_DONE);
    assign o_res.value          = r_value;
    assign o_res.at_end         = w_end;
    assign o_res.bytes_skipped  = r_skipped;
    assign o_res.append_dropped = r_dropped;

    // Checks
    a_cursor_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= r_fill)
        else $error("cursor beyond fill length");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= C_LEN_W'(BUFFER_BYTES))
        else $error("fill length beyond buffer");

    a_bit_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_br >= C_MIN_START) && (r_br <= C_BITS_PER_BYTE))
        else $error("bit position out of range");

    a_load_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |=> (r_state == ST_LATCH))
        else $error("byte fetch not followed by capture");

    a_suffix_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_BITS) && ((r_kind == KIND_UE) || (r_kind == KIND_SE)))
            |-> (r_cnt <= C_CNT_W'(C_MAX_ZEROS)))
        else $error("code suffix too long");

endmodule

// File: design/exp_golomb_bit_reader_unit.sv
// Exp-Golomb bitstream reader.
// i_cmd carries one command per transfer: append a byte, read or peek an
// n-bit field (up to 32 bits), read a ue or se code, skip whole bytes, or
// clear and rewind. o_rsp returns exactly one result per command: value,
// at_end, bytes_skipped and append_dropped. The APB port holds one register,
// start_bits_left at address 0, which sets the bit position after a clear.
// Commands are handled one at a time, one bit per cycle through the cached
// cursor byte while no buffer byte has to be fetched; a read, peek, ue or se
// code fetches each buffer byte it needs with one memory read. Append, skip,
// clear and the unused code need no fetch and go straight to their result.
// The result sits in an output register, so the next command is accepted
// while it waits; a stalled receiver holds at most that one result and the
// following command waits in its final step until the register frees.
// Reset empties the buffer, puts the bit position at 8 and sets the register
// to 8; the byte store itself is not cleared, and commands are taken in the
// first cycle after reset.
module exp_golomb_bit_reader_unit import egbr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    egbr_cmd_if.sink             i_cmd,
    egbr_rsp_if.source           o_rsp,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [C_PADDR_W-1:0] paddr,
    input  logic [C_PDATA_W-1:0] pwdata,
    output logic [C_PDATA_W-1:0] prdata,
    output logic                 pready
);

    // Configuration register
    logic [C_CFG_W-1:0] r_start_bits, n_start_bits;
    logic               w_sel_start;
    logic [C_BR_W-1:0]  w_start_clamped;

    assign w_sel_start = (paddr[2] == REG_START_BITS);
    assign pready      = 1'b1;
    assign prdata      = w_sel_start ? C_PDATA_W'(r_start_bits) : '0;

    always_comb begin
        n_start_bits = r_start_bits;
        if (psel && penable && pwrite && w_sel_start) begin
            n_start_bits = pwdata[C_CFG_W-1:0];
        end
    end

    // Start position limited to 1..8
    assign w_start_clamped = (r_start_bits < C_MIN_START)     ? C_MIN_START :
                             (r_start_bits > C_BITS_PER_BYTE) ? C_BITS_PER_BYTE :
                             r_start_bits;

    // Reader core
    logic    w_res_valid;
    logic    w_res_ready;
    t_result w_res;

    egbr_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .i_start_bits (w_start_clamped),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res),
        .i_res_ready  (w_res_ready)
    );

    // Output register
    logic    r_rsp_valid, n_rsp_valid;
    t_result r_rsp, n_rsp;

    assign w_res_ready = !r_rsp_valid || o_rsp.ready;

    always_comb begin
        n_rsp_valid = r_rsp_valid;
        n_rsp       = r_rsp;
        if (w_res_valid && w_res_ready) begin
            n_rsp_valid = 1'b1;
            n_rsp       = w_res;
        end else if (o_rsp.ready) begin
            n_rsp_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_bits <= C_BITS_PER_BYTE;
            r_rsp_valid  <= 1'b0;
        end else begin
            r_start_bits <= n_start_bits;
            r_rsp_valid  <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_rsp.valid          = r_rsp_valid;
    assign o_rsp.value          = r_rsp.value;
    assign o_rsp.at_end         = r_rsp.at_end;
    assign o_rsp.bytes_skipped  = r_rsp.bytes_skipped;
    assign o_rsp.append_dropped = r_rsp.append_dropped;

endmodule

// File: tb/tb_exp_golomb_bit_reader_unit.sv
`timescale 1ns / 1ps

module tb_exp_golomb_bit_reader_unit;
    import egbr_pkg::*;

    localparam logic [C_KIND_W-1:0]  KIND_UNUSED     = 3'd7;
    localparam logic [C_PADDR_W-1:0] ADDR_START_BITS = {REG_START_BITS, 2'b00};
    localparam int                   RANDOM_PER_PHASE = 90;

    typedef struct packed {
        logic [C_KIND_W-1:0]  kind;
        logic [C_BYTE_W-1:0]  data_byte;
        logic [C_NBITS_W-1:0] bit_count;
        logic [C_SKIP_W-1:0]  skip_count;
    } t_cmd;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [C_PADDR_W-1:0] paddr;
    logic [C_PDATA_W-1:0] pwdata;
    logic [C_PDATA_W-1:0] prdata;
    logic                 pready;

    egbr_cmd_if cmd_bus ();
    egbr_rsp_if rsp_bus ();

    exp_golomb_bit_reader_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_rsp   (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow copy of the reader state
    logic [C_BYTE_W-1:0] buf_mem [BUFFER_BYTES];
    logic [C_LEN_W-1:0]  buf_fill;
    logic [C_LEN_W-1:0]  rd_byte;
    logic [C_BR_W-1:0]   rd_bits;
    logic [C_CFG_W-1:0]  start_bits_cfg;

    t_cmd    pending_cmds [$];
    t_result expected_rsps [$];
    int      items_sent;
    int      results_seen;
    int      err_cnt;

    t_cmd    drv_item;
    t_result drv_pred;
    t_result mon_want;
    int      drv_gap;
    bit      drv_burst;
    int      sink_stall;
    bit      sink_burst;

    // ------------------------------------------------------------------
    // Bit reader model
    // ------------------------------------------------------------------
    function automatic logic cursor_at_end();
        return rd_byte >= buf_fill;
    endfunction

    // MSB-first single bit; past the end reads 0 and the cursor holds
    function automatic logic take_bit();
        logic b;
        if (cursor_at_end())
            return 1'b0;
        rd_bits = rd_bits - 1'b1;
        b = buf_mem[rd_byte[C_ADDR_W-1:0]][rd_bits[C_BIDX_W-1:0]];
        if (rd_bits == '0) begin
            rd_byte = rd_byte + 1'b1;
            rd_bits = C_BITS_PER_BYTE;
        end
        return b;
    endfunction

    function automatic logic [C_VALUE_W-1:0] take_field(input int nbits);
        logic [C_VALUE_W-1:0] r;
        int cnt;
        r   = '0;
        cnt = (nbits > 32) ? 32 : nbits;
        for (int i = 0; i < cnt; i++)
            r = {r[C_VALUE_W-2:0], take_bit()};
        return r;
    endfunction

    // Leading-zero count stops at 31, or at the end right after a zero
    function automatic logic [C_VALUE_W-1:0] take_ue();
        int zeros;
        zeros = 0;
        while (1) begin
            if (take_bit())
                break;
            if (zeros >= 31)
                break;
            if (cursor_at_end())
                break;
            zeros++;
        end
        return take_field(zeros) + ((32'd1 << zeros) - 32'd1);
    endfunction

    function automatic t_result decode_cmd(input t_cmd c);
        t_result              r;
        logic [C_VALUE_W-1:0] k;
        logic [C_LEN_W-1:0]   save_byte;
        logic [C_BR_W-1:0]    save_bits;
        logic [C_CMP_W-1:0]   left;
        logic [C_BR_W-1:0]    s;
        r = '0;
        case (c.kind)
            KIND_APPEND: begin
                if (buf_fill < BUFFER_BYTES) begin
                    buf_mem[buf_fill[C_ADDR_W-1:0]] = c.data_byte;
                    buf_fill = buf_fill + 1'b1;
                end else begin
                    r.append_dropped = 1'b1;
                end
            end
            KIND_READ: begin
                r.value = take_field(c.bit_count);
            end
            KIND_PEEK: begin
                save_byte = rd_byte;
                save_bits = rd_bits;
                r.value   = take_field(c.bit_count);
                rd_byte   = save_byte;
                rd_bits   = save_bits;
            end
            KIND_UE: begin
                r.value = take_ue();
            end
            KIND_SE: begin
                k = take_ue();
                r.value = k[0] ? (k >> 1) + 32'd1 : 32'd0 - (k >> 1);
            end
            KIND_SKIP: begin
                left = cursor_at_end() ? '0 : buf_fill - rd_byte;
                r.bytes_skipped = (c.skip_count < left) ? c.skip_count : left;
                rd_byte = rd_byte + r.bytes_skipped;
            end
            KIND_CLEAR: begin
                s = start_bits_cfg;
                if (s < C_MIN_START)
                    s = C_MIN_START;
                if (s > C_BITS_PER_BYTE)
                    s = C_BITS_PER_BYTE;
                buf_fill = '0;
                rd_byte  = '0;
                rd_bits  = s;
            end
            default: begin
            end
        endcase
        r.at_end = cursor_at_end();
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------
    // Mostly short gaps, a few long ones; none in burst stretches
    function automatic int next_gap(input bit burst);
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Zero-heavy bytes so that long ue prefixes show up
    function automatic logic [C_BYTE_W-1:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return 8'h00;
        if (r == 3)
            return C_BYTE_W'($urandom_range(1, 3));
        return C_BYTE_W'($urandom());
    endfunction

    function automatic logic [C_NBITS_W-1:0] pick_nbits();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return C_MAX_BITS;
        if (r == 2)
            return C_NBITS_W'($urandom_range(33, 63));
        return C_NBITS_W'($urandom_range(1, 31));
    endfunction

    function automatic logic [C_SKIP_W-1:0] pick_skip();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return C_SKIP_W'($urandom_range(0, 2047));
        if (r == 1)
            return '0;
        return C_SKIP_W'($urandom_range(1, 4));
    endfunction

    function automatic logic [C_KIND_W-1:0] pick_parse_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 28)
            return KIND_READ;
        if (r < 38)
            return KIND_PEEK;
        if (r < 58)
            return KIND_UE;
        if (r < 78)
            return KIND_SE;
        if (r < 86)
            return KIND_SKIP;
        if (r < 93)
            return KIND_APPEND;
        if (r < 96)
            return KIND_CLEAR;
        return KIND_UNUSED;
    endfunction

    task automatic push_cmd(input logic [C_KIND_W-1:0] kind, input logic [C_BYTE_W-1:0] data,
                            input logic [C_NBITS_W-1:0] nbits,
                            input logic [C_SKIP_W-1:0] skip);
        t_cmd c;
        c.kind       = kind;
        c.data_byte  = data;
        c.bit_count  = nbits;
        c.skip_count = skip;
        pending_cmds.push_back(c);
        items_sent++;
    endtask

    // Unused fields carry random noise
    task automatic push_random(input logic [C_KIND_W-1:0] kind);
        push_cmd(kind, pick_byte(), pick_nbits(), pick_skip());
    endtask

    // Append a short random stream, then parse it, often past its end
    task automatic run_random(input int count);
        int made;
        int n;
        made = 0;
        while (made < count) begin
            if ($urandom_range(0, 3) == 0) begin
                push_random(KIND_CLEAR);
                made++;
            end
            n = $urandom_range(1, 10);
            repeat (n) begin
                push_random(KIND_APPEND);
                made++;
            end
            n = $urandom_range(2, 12);
            repeat (n) begin
                push_random(pick_parse_kind());
                made++;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, name, want, got);
            err_cnt++;
        end
    endtask

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    task automatic apb_access(input logic wr, input logic [C_PDATA_W-1:0] wdata,
                              output logic [C_PDATA_W-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_START_BITS;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic read_start_bits();
        logic [C_PDATA_W-1:0] rd;
        apb_access(1'b0, '0, rd);
        check_field("start_bits_left readback", 32'(start_bits_cfg), rd);
    endtask

    // Upper data bits are junk; only the low nibble is kept
    task automatic set_start_bits(input logic [C_CFG_W-1:0] val);
        logic [C_PDATA_W-1:0] wdata;
        logic [C_PDATA_W-1:0] rd;
        wdata = $urandom();
        wdata[C_CFG_W-1:0] = val;
        apb_access(1'b1, wdata, rd);
        start_bits_cfg = val;
        read_start_bits();
    endtask

    task automatic wait_for_results();
        do @(posedge i_clk); while (results_seen != items_sent);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Command driver: model runs at each transfer
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_bus.valid <= 1'b0;
        end else begin
            if (cmd_bus.valid && cmd_bus.ready) begin
                drv_pred = decode_cmd(drv_item);
                expected_rsps.push_back(drv_pred);
            end
            if (!cmd_bus.valid || cmd_bus.ready) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    cmd_bus.valid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    drv_item = pending_cmds.pop_front();
                    cmd_bus.valid      <= 1'b1;
                    cmd_bus.kind       <= drv_item.kind;
                    cmd_bus.data_byte  <= drv_item.data_byte;
                    cmd_bus.bit_count  <= drv_item.bit_count;
                    cmd_bus.skip_count <= drv_item.skip_count;
                    if ($urandom_range(0, 49) == 0)
                        drv_burst = !drv_burst;
                    drv_gap = next_gap(drv_burst);
                end else begin
                    cmd_bus.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor with random backpressure
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                results_seen++;
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got value 0x%0h",
                             $realtime, rsp_bus.value);
                    err_cnt++;
                end else begin
                    mon_want = expected_rsps.pop_front();
                    check_field("value", mon_want.value, rsp_bus.value);
                    check_field("at_end", 32'(mon_want.at_end), 32'(rsp_bus.at_end));
                    check_field("bytes_skipped", 32'(mon_want.bytes_skipped),
                                32'(rsp_bus.bytes_skipped));
                    check_field("append_dropped", 32'(mon_want.append_dropped),
                                32'(rsp_bus.append_dropped));
                end
            end
            if (sink_stall > 0) begin
                sink_stall--;
                rsp_bus.ready <= 1'b0;
            end else if (!sink_burst && $urandom_range(0, 4) == 0) begin
                sink_stall = next_gap(1'b0);
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= 1'b1;
            end
            if ($urandom_range(0, 99) == 0)
                sink_burst = !sink_burst;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial begin
        #4000000;
        $display("** exp_golomb_bit_reader_unit: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        logic [C_CFG_W-1:0] phase_cfg [5];

        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        cmd_bus.valid      = 1'b0;
        cmd_bus.kind       = KIND_APPEND;
        cmd_bus.data_byte  = '0;
        cmd_bus.bit_count  = '0;
        cmd_bus.skip_count = '0;
        rsp_bus.ready      = 1'b0;
        buf_fill           = '0;
        rd_byte            = '0;
        rd_bits            = C_BITS_PER_BYTE;
        start_bits_cfg     = C_BITS_PER_BYTE;
        items_sent         = 0;
        results_seen       = 0;
        err_cnt            = 0;
        drv_gap            = 0;
        drv_burst          = 1'b0;
        sink_stall         = 0;
        sink_burst         = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Register comes up at 8
        read_start_bits();

        // Directed: empty buffer, unused code, then a hand-made stream
        push_cmd(KIND_READ, 8'h00, 6'd8, 11'd0);
        push_cmd(KIND_UE, 8'h00, 6'd0, 11'd0);
        push_cmd(KIND_SKIP, 8'h00, 6'd0, 11'd5);
        push_cmd(KIND_UNUSED, 8'hFF, 6'h3F, 11'h7FF);
        push_cmd(KIND_APPEND, 8'hFF, 6'd0, 11'd0);
        push_cmd(KIND_APPEND, 8'h80, 6'd0, 11'd0);
        push_cmd(KIND_APPEND, 8'h00, 6'd0, 11'd0);
        push_cmd(KIND_APPEND, 8'h00, 6'd0, 11'd0);
        push_cmd(KIND_APPEND, 8'h00, 6'd0, 11'd0);
        push_cmd(KIND_APPEND, 8'h01, 6'd0, 11'd0);
        push_cmd(KIND_APPEND, 8'hA5, 6'd0, 11'd0);
        push_cmd(KIND_APPEND, 8'h3C, 6'd0, 11'd0);
        push_cmd(KIND_PEEK, 8'h00, C_MAX_BITS, 11'd0);
        push_cmd(KIND_PEEK, 8'h00, 6'd63, 11'd0);       // oversized count
        push_cmd(KIND_READ, 8'h00, 6'd0, 11'd0);
        push_cmd(KIND_READ, 8'h00, 6'd1, 11'd0);
        push_cmd(KIND_READ, 8'h00, 6'd7, 11'd0);
        push_cmd(KIND_UE, 8'h00, 6'd0, 11'd0);
        push_cmd(KIND_SE, 8'h00, 6'd0, 11'd0);          // zero run hits the cap
        push_cmd(KIND_SKIP, 8'h00, 6'd0, 11'd1);
        push_cmd(KIND_SE, 8'h00, 6'd0, 11'd0);
        push_cmd(KIND_SKIP, 8'h00, 6'd0, 11'h7FF);      // clipped to what is left
        push_cmd(KIND_READ, 8'h00, C_MAX_BITS, 11'd0);  // past the end
        push_cmd(KIND_PEEK, 8'h00, C_MAX_BITS, 11'd0);
        push_cmd(KIND_CLEAR, 8'h00, 6'd0, 11'd0);
        wait_for_results();

        // Phases over rewind settings, out-of-range ones included
        phase_cfg[0] = 4'd1;
        phase_cfg[1] = 4'd0;
        phase_cfg[2] = 4'd15;
        phase_cfg[3] = C_CFG_W'($urandom_range(2, 7));
        phase_cfg[4] = 4'd8;
        for (int p = 0; p < 5; p++) begin
            set_start_bits(phase_cfg[p]);
            push_random(KIND_CLEAR);
            if (p == 2) begin
                // Longer stream, then skip far and work near its end
                repeat (40) push_random(KIND_APPEND);
                push_cmd(KIND_READ, 8'h00, C_MAX_BITS, 11'd0);
                push_cmd(KIND_READ, 8'h00, C_MAX_BITS, 11'd0);
                push_cmd(KIND_SKIP, 8'h00, 6'd0, 11'd1000);
                push_cmd(KIND_PEEK, 8'h00, C_MAX_BITS, 11'd0);
                push_cmd(KIND_UE, 8'h00, 6'd0, 11'd0);
                push_cmd(KIND_SE, 8'h00, 6'd0, 11'd0);
                push_cmd(KIND_SKIP, 8'h00, 6'd0, 11'h7FF);
                push_cmd(KIND_READ, 8'h00, 6'd20, 11'd0);
                push_cmd(KIND_APPEND, 8'h5A, 6'd0, 11'd0);
                push_cmd(KIND_CLEAR, 8'h00, 6'd0, 11'd0);
                push_cmd(KIND_APPEND, 8'hC3, 6'd0, 11'd0);
                push_cmd(KIND_READ, 8'h00, 6'd8, 11'd0);
            end
            run_random(RANDOM_PER_PHASE);
            wait_for_results();
        end

        // Drain and allow for any stray late result
        repeat (100) @(posedge i_clk);
        if (err_cnt == 0 && expected_rsps.size() == 0) begin
            $display("** exp_golomb_bit_reader_unit: PASSED **");
        end else begin
            $display("** exp_golomb_bit_reader_unit: FAILED **");
        end
        $finish;
    end

endmodule
